FILE: rtl/core/exdes_pkg.sv
package exdes_pkg;

   // Configuration port geometry.
   localparam int unsigned CFG_INDEX_WIDTH = 2;
   localparam int unsigned CFG_DATA_WIDTH  = 32;

   // Register indexes on the configuration port.
   typedef enum logic [CFG_INDEX_WIDTH-1:0] {
      CFG_HEAP_OFFSET   = 2'd0,
      CFG_SECTOR_SHIFT  = 2'd1,
      CFG_CLUSTER_SHIFT = 2'd2,
      CFG_DEEP_SCAN     = 2'd3
   } cfg_index_type;

   // Report codes carried in the action field.
   typedef enum logic [1:0] {
      ACTION_DELETED_FILE = 2'd0,
      ACTION_VISIT_DIR    = 2'd1,
      ACTION_END_OF_DIR   = 2'd2
   } action_type;

   // Directory entry type codes.
   localparam logic [7:0] ENTRY_TYPE_END   = 8'h00;
   localparam logic [6:0] TYPE_FILE        = 7'h05;
   localparam logic [6:0] TYPE_STREAM      = 7'h40;
   localparam logic [6:0] TYPE_NAME        = 7'h41;
   localparam int unsigned IN_USE_BIT      = 7;
   localparam int unsigned ATTR_DIR_BIT    = 4;
   localparam logic [31:0] MIN_DATA_CLUSTER = 32'd2;

   // Width of the sum of the sector and cluster shifts.
   localparam int unsigned SHIFT_SUM_WIDTH = 6;

   // Configuration register file contents.
   typedef struct packed {
      logic [31:0] heap_offset_sectors;
      logic [3:0]  sector_shift;
      logic [4:0]  cluster_shift;
      logic        deep_scan;
   } cfg_type;

   // One incoming directory entry with its framing flags.
   typedef struct packed {
      logic [63:0] entry_bytes_0_7;
      logic [63:0] entry_bytes_8_15;
      logic [63:0] entry_bytes_16_23;
      logic [63:0] entry_bytes_24_31;
      logic        last_in_cluster;
      logic        directory_start;
   } entry_type;

   // Closed entry set or end of directory, handed from front to back.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] first_cluster;
      logic [63:0] data_length;
      logic [31:0] create_stamp;
      logic [31:0] modify_stamp;
   } set_report_type;

   // Complete result item.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] first_cluster;
      logic [63:0] data_length;
      logic [31:0] create_stamp;
      logic [31:0] modify_stamp;
      logic [63:0] volume_offset;
      logic [63:0] run_start;
      logic [63:0] run_clusters;
      logic        has_location;
      logic        good_confidence;
      logic        has_timestamps;
   } result_type;

   // Scan state of the front end.
   typedef enum logic [1:0] {
      FRONT_SCAN   = 2'd0,
      FRONT_IN_SET = 2'd1,
      FRONT_ENDED  = 2'd2
   } front_state_type;

endpackage

FILE: rtl/core/exdes_req_if.sv
interface exdes_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] entry_bytes_0_7;
   logic [63:0] entry_bytes_8_15;
   logic [63:0] entry_bytes_16_23;
   logic [63:0] entry_bytes_24_31;
   logic        last_in_cluster;
   logic        directory_start;

   modport source (
      output valid, entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23,
             entry_bytes_24_31, last_in_cluster, directory_start,
      input  ready
   );

   modport sink (
      input  valid, entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23,
             entry_bytes_24_31, last_in_cluster, directory_start,
      output ready
   );
endinterface

FILE: rtl/core/exdes_rsp_if.sv
interface exdes_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] first_cluster;
   logic [63:0] data_length;
   logic [31:0] create_stamp;
   logic [31:0] modify_stamp;
   logic [63:0] volume_offset;
   logic [63:0] run_start;
   logic [63:0] run_clusters;
   logic        has_location;
   logic        good_confidence;
   logic        has_timestamps;

   modport source (
      output valid, action, first_cluster, data_length, create_stamp, modify_stamp,
             volume_offset, run_start, run_clusters, has_location, good_confidence,
             has_timestamps,
      input  ready
   );

   modport sink (
      input  valid, action, first_cluster, data_length, create_stamp, modify_stamp,
             volume_offset, run_start, run_clusters, has_location, good_confidence,
             has_timestamps,
      output ready
   );
endinterface

FILE: rtl/core/exdes_front.sv
module exdes_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  exdes_pkg::entry_type      in_entry,
   input  logic                      deep_scan,
   input  logic                      queue_full,
   output logic                      push,
   output exdes_pkg::set_report_type push_report
);
   import exdes_pkg::*;

   front_state_type state_ff, state_in;
   logic [7:0]      secondaries_left_ff, secondaries_left_in;
   logic            set_in_use_ff, set_in_use_in;
   logic            set_is_dir_ff, set_is_dir_in;
   logic [31:0]     held_create_ff, held_create_in;
   logic [31:0]     held_modify_ff, held_modify_in;
   logic [31:0]     held_cluster_ff, held_cluster_in;
   logic [63:0]     held_length_ff, held_length_in;
   logic            name_seen_ff, name_seen_in;

   logic            accept;
   front_state_type eff_state;
   logic [7:0]      entry_type_code;
   logic [6:0]      masked_type;
   logic [7:0]      entry_count;
   logic [7:0]      left_dec;
   logic            last;
   logic            set_done;
   logic            primary_done;
   logic [31:0]     cluster_upd;
   logic [63:0]     length_upd;
   logic            name_upd;
   logic            loc;

   // An entry may always produce a report, so take it only with queue room.
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Field extraction from the entry.
   assign entry_type_code = in_entry.entry_bytes_0_7[7:0];
   assign masked_type     = entry_type_code[6:0];
   assign entry_count     = in_entry.entry_bytes_0_7[15:8];
   assign last            = in_entry.last_in_cluster;

   // A new directory drops any open set and the end marker.
   assign eff_state = in_entry.directory_start ? FRONT_SCAN : state_ff;

   // Secondary bookkeeping and updated set contents.
   always_comb begin
      left_dec     = (secondaries_left_ff != 8'd0) ? secondaries_left_ff - 8'd1 : 8'd0;
      set_done     = (left_dec == 8'd0) || last;
      primary_done = (entry_count == 8'd0) || last;
      cluster_upd  = (masked_type == TYPE_STREAM) ? in_entry.entry_bytes_16_23[63:32]
                                                  : held_cluster_ff;
      length_upd   = (masked_type == TYPE_STREAM) ? in_entry.entry_bytes_24_31
                                                  : held_length_ff;
      name_upd     = name_seen_ff ||
                     ((masked_type == TYPE_NAME) && (in_entry.entry_bytes_0_7[31:16] != 16'd0));
      loc          = cluster_upd >= MIN_DATA_CLUSTER;
   end

   // Next scan state.
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (eff_state)
            FRONT_SCAN: begin
               if (entry_type_code == ENTRY_TYPE_END) begin
                  state_in = FRONT_ENDED;
               end else if (masked_type == TYPE_FILE) begin
                  state_in = primary_done ? FRONT_SCAN : FRONT_IN_SET;
               end else begin
                  state_in = FRONT_SCAN;
               end
            end
            FRONT_IN_SET: begin
               state_in = set_done ? FRONT_SCAN : FRONT_IN_SET;
            end
            FRONT_ENDED: begin
               state_in = FRONT_ENDED;
            end
            default: begin
               state_in = FRONT_SCAN;
            end
         endcase
      end
   end

   // Held set contents and the report pushed into the queue.
   always_comb begin
      secondaries_left_in = secondaries_left_ff;
      set_in_use_in       = set_in_use_ff;
      set_is_dir_in       = set_is_dir_ff;
      held_create_in      = held_create_ff;
      held_modify_in      = held_modify_ff;
      held_cluster_in     = held_cluster_ff;
      held_length_in      = held_length_ff;
      name_seen_in        = name_seen_ff;
      push                = 1'b0;
      push_report         = '0;
      if (accept) begin
         case (eff_state)
            FRONT_SCAN: begin
               if (entry_type_code == ENTRY_TYPE_END) begin
                  push               = 1'b1;
                  push_report.action = ACTION_END_OF_DIR;
               end else if (masked_type == TYPE_FILE) begin
                  // A set closed at its primary never has a report.
                  secondaries_left_in = primary_done ? 8'd0 : entry_count;
                  set_in_use_in       = entry_type_code[IN_USE_BIT];
                  set_is_dir_in       = in_entry.entry_bytes_0_7[32 + ATTR_DIR_BIT];
                  held_create_in      = in_entry.entry_bytes_8_15[31:0];
                  held_modify_in      = in_entry.entry_bytes_8_15[63:32];
                  held_cluster_in     = 32'd0;
                  held_length_in      = 64'd0;
                  name_seen_in        = 1'b0;
               end
            end
            FRONT_IN_SET: begin
               secondaries_left_in = set_done ? 8'd0 : left_dec;
               held_cluster_in     = cluster_upd;
               held_length_in      = length_upd;
               name_seen_in        = name_upd;
               push_report.first_cluster = cluster_upd;
               push_report.data_length   = length_upd;
               push_report.create_stamp  = held_create_ff;
               push_report.modify_stamp  = held_modify_ff;
               if (set_done) begin
                  if (!set_in_use_ff && !set_is_dir_ff && name_upd) begin
                     push               = 1'b1;
                     push_report.action = ACTION_DELETED_FILE;
                  end else if (set_is_dir_ff && loc && (set_in_use_ff || deep_scan)) begin
                     push               = 1'b1;
                     push_report.action = ACTION_VISIT_DIR;
                  end
               end
            end
            FRONT_ENDED: begin
               push = 1'b0;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // Scan state and held set registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= FRONT_SCAN;
         secondaries_left_ff <= 8'd0;
         set_in_use_ff       <= 1'b0;
         set_is_dir_ff       <= 1'b0;
         held_create_ff      <= 32'd0;
         held_modify_ff      <= 32'd0;
         held_cluster_ff     <= 32'd0;
         held_length_ff      <= 64'd0;
         name_seen_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         secondaries_left_ff <= secondaries_left_in;
         set_in_use_ff       <= set_in_use_in;
         set_is_dir_ff       <= set_is_dir_in;
         held_create_ff      <= held_create_in;
         held_modify_ff      <= held_modify_in;
         held_cluster_ff     <= held_cluster_in;
         held_length_ff      <= held_length_in;
         name_seen_ff        <= name_seen_in;
      end
   end

endmodule

FILE: rtl/core/exdes_queue.sv
module exdes_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  exdes_pkg::set_report_type push_data,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output exdes_pkg::set_report_type pop_data
);
   import exdes_pkg::*;

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

   set_report_type         entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, written at the tail.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/exdes_back.sv
module exdes_back (
   input  logic                      clock,
   input  logic                      reset,
   input  exdes_pkg::cfg_type        cfg,
   input  logic                      q_valid,
   input  exdes_pkg::set_report_type q_data,
   output logic                      q_pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output exdes_pkg::result_type     out_item
);
   import exdes_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   set_report_type             s1_report_ff;
   logic                       s1_loc_ff, s1_loc_in;
   logic [63:0]                s1_sum_ff, s1_sum_in;
   logic [63:0]                s1_runs_ff, s1_runs_in;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_item_ff, out_item_in;

   logic                       advance;
   logic [SHIFT_SUM_WIDTH-1:0] total_shift;
   logic [63:0]                rel;
   logic [63:0]                low_mask;
   logic [63:0]                voff;

   // The whole back end moves when the output register is free or drained.
   assign advance     = !out_valid_ff || out_ready;
   assign q_pop       = q_valid && advance;
   assign total_shift = SHIFT_SUM_WIDTH'(cfg.sector_shift) + SHIFT_SUM_WIDTH'(cfg.cluster_shift);

   // First stage: cluster to sector offset and cluster count of the data.
   always_comb begin
      s1_loc_in   = q_data.first_cluster >= MIN_DATA_CLUSTER;
      rel         = {32'd0, q_data.first_cluster - MIN_DATA_CLUSTER} << cfg.cluster_shift;
      s1_sum_in   = {32'd0, cfg.heap_offset_sectors} + rel;
      low_mask    = ~({64{1'b1}} << total_shift);
      if (q_data.data_length == 64'd0) begin
         s1_runs_in = 64'd1;
      end else begin
         s1_runs_in = (q_data.data_length >> total_shift) +
                      {63'd0, |(q_data.data_length & low_mask)};
      end
      s1_valid_in = q_valid;
   end

   // Second stage: byte offset, run start and the flags.
   always_comb begin
      voff                        = s1_loc_ff ? (s1_sum_ff << cfg.sector_shift) : 64'd0;
      out_item_in.action          = s1_report_ff.action;
      out_item_in.first_cluster   = s1_report_ff.first_cluster;
      out_item_in.data_length     = s1_report_ff.data_length;
      out_item_in.create_stamp    = s1_report_ff.create_stamp;
      out_item_in.modify_stamp    = s1_report_ff.modify_stamp;
      out_item_in.volume_offset   = voff;
      out_item_in.run_start       = voff >> total_shift;
      out_item_in.run_clusters    = s1_loc_ff ? s1_runs_ff : 64'd0;
      out_item_in.has_location    = s1_loc_ff;
      out_item_in.good_confidence = s1_loc_ff && (s1_report_ff.data_length != 64'd0);
      out_item_in.has_timestamps  = s1_report_ff.modify_stamp != 32'd0;
      out_valid_in                = s1_valid_ff;
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of both stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_report_ff <= q_data;
         s1_loc_ff    <= s1_loc_in;
         s1_sum_ff    <= s1_sum_in;
         s1_runs_ff   <= s1_runs_in;
         out_item_ff  <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

FILE: rtl/core/exfat_dir_entry_set_parser_unit.sv
// Takes one 32-byte directory entry per cycle; the input stalls only when the report queue is full.
// A report passes through a queue write, an offset stage and the output register before it
// appears, and a stall on the result side holds the back end.
// Sustained rate is one entry per cycle while the queue has room, set by the front end scan logic.
// Reset is synchronous and active high; it empties the queue and pipeline, clears the scan state
// and returns the registers to heap offset 0, sector shift 9, cluster shift 0 and no deep scan.
module exfat_dir_entry_set_parser_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   exdes_req_if.sink                              req_chan,
   exdes_rsp_if.source                            rsp_chan,
   input  logic                                   csr_wr_en,
   input  logic [exdes_pkg::CFG_INDEX_WIDTH-1:0]  csr_index,
   input  logic [exdes_pkg::CFG_DATA_WIDTH-1:0]   csr_wdata
);
   import exdes_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   entry_type      entry;
   logic           queue_full;
   logic           push;
   set_report_type push_report;
   logic           q_valid;
   logic           q_pop;
   set_report_type q_data;
   logic           out_valid;
   result_type     out_item;

   // Register writes from the configuration port.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (cfg_index_type'(csr_index))
            CFG_HEAP_OFFSET:   cfg_in.heap_offset_sectors = csr_wdata[31:0];
            CFG_SECTOR_SHIFT:  cfg_in.sector_shift        = csr_wdata[3:0];
            CFG_CLUSTER_SHIFT: cfg_in.cluster_shift       = csr_wdata[4:0];
            CFG_DEEP_SCAN:     cfg_in.deep_scan           = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heap_offset_sectors <= 32'd0;
         cfg_ff.sector_shift        <= 4'd9;
         cfg_ff.cluster_shift       <= 5'd0;
         cfg_ff.deep_scan           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Gather the incoming transaction payload.
   always_comb begin
      entry.entry_bytes_0_7   = req_chan.entry_bytes_0_7;
      entry.entry_bytes_8_15  = req_chan.entry_bytes_8_15;
      entry.entry_bytes_16_23 = req_chan.entry_bytes_16_23;
      entry.entry_bytes_24_31 = req_chan.entry_bytes_24_31;
      entry.last_in_cluster   = req_chan.last_in_cluster;
      entry.directory_start   = req_chan.directory_start;
   end

   exdes_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_entry    (entry),
      .deep_scan   (cfg_ff.deep_scan),
      .queue_full  (queue_full),
      .push        (push),
      .push_report (push_report)
   );

   exdes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_report),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   exdes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   // Drive the result transaction.
   always_comb begin
      rsp_chan.valid           = out_valid;
      rsp_chan.action          = out_item.action;
      rsp_chan.first_cluster   = out_item.first_cluster;
      rsp_chan.data_length     = out_item.data_length;
      rsp_chan.create_stamp    = out_item.create_stamp;
      rsp_chan.modify_stamp    = out_item.modify_stamp;
      rsp_chan.volume_offset   = out_item.volume_offset;
      rsp_chan.run_start       = out_item.run_start;
      rsp_chan.run_clusters    = out_item.run_clusters;
      rsp_chan.has_location    = out_item.has_location;
      rsp_chan.good_confidence = out_item.good_confidence;
      rsp_chan.has_timestamps  = out_item.has_timestamps;
   end

endmodule
